### rtl/htc_pkg.sv
`timescale 1ns / 1ps

package htc_pkg;

    // beat payload types
    typedef logic signed [14:0] t_temp_centi;
    typedef logic        [13:0] t_rh_centi;
    typedef logic        [9:0]  t_rh_tenths;
    typedef logic        [6:0]  t_rh_percent;

    // configuration port
    localparam int unsigned CFG_ADDR_W = 5;
    localparam logic [2:0] REG_KNEE_TEMP  = 3'd0;
    localparam logic [2:0] REG_COLD_DELTA = 3'd1;
    localparam logic [2:0] REG_DELTA_MIN  = 3'd2;
    localparam logic [2:0] REG_DELTA_MAX  = 3'd3;
    localparam logic [2:0] REG_RH_CEILING = 3'd4;

    localparam logic signed [11:0] KNEE_TEMP_RST  = 12'sd400;
    localparam logic signed [7:0]  COLD_DELTA_RST = -8'sd44;
    localparam logic signed [7:0]  DELTA_MIN_RST  = -8'sd60;
    localparam logic signed [7:0]  DELTA_MAX_RST  = -8'sd30;
    localparam logic        [9:0]  RH_CEILING_RST = 10'd990;

    // cubic coefficients in q40, pre-scaled to the common denominator 1000
    localparam logic signed [30:0] CUBIC_A     = 31'sd57427;
    localparam logic signed [30:0] CUBIC_B10   = 31'sd88109360;
    localparam logic signed [41:0] CUBIC_C100  = 42'sd95209515600;
    localparam logic signed [52:0] CUBIC_D1000 = 53'sd92194049989000;

    // linear delta and output scale
    localparam logic signed [15:0] LIN_SLOPE  = 16'sd12;
    localparam logic signed [15:0] LIN_OFFSET = 16'sd9200;
    localparam logic signed [21:0] RH_SCALE   = 22'sd92;

    // reciprocal multipliers for constant division
    localparam logic [18:0] DIV10_MUL   = 19'd419431;
    localparam logic [21:0] DIV100_MUL  = 22'd2684355;
    localparam logic [20:0] DIV1000_MUL = 21'd1073742;
    localparam logic [19:0] DIGIT_BASE  = 20'd1000;

    // floor(x / 10), exact for x below 2^18
    function automatic logic [14:0] f_div10(input logic [17:0] x);
        logic [36:0] p;
        p = 37'(x) * 37'(DIV10_MUL);
        return p[36:22];
    endfunction

    // floor(x / 100), exact for x below 2^21
    function automatic logic [14:0] f_div100(input logic [20:0] x);
        logic [42:0] p;
        p = 43'(x) * 43'(DIV100_MUL);
        return p[42:28];
    endfunction

    // one decimal-thousand digit: floor(x / 1000), x below 1000 * 1024
    function automatic logic [9:0] f_div1000_digit(input logic [19:0] x);
        logic [40:0] p;
        p = 41'(x) * 41'(DIV1000_MUL);
        return p[39:30];
    endfunction

endpackage

### rtl/htc_in_if.sv
`timescale 1ns / 1ps

interface htc_in_if import htc_pkg::*;;
    logic        valid;
    logic        ready;
    t_temp_centi temp_centi;
    t_rh_centi   rh_centi;

    modport source (output valid, output temp_centi, output rh_centi, input ready);
    modport sink   (input valid, input temp_centi, input rh_centi, output ready);
endinterface

### rtl/htc_out_if.sv
`timescale 1ns / 1ps

interface htc_out_if import htc_pkg::*;;
    logic        valid;
    logic        ready;
    t_rh_tenths  rh_tenths;
    t_rh_percent rh_percent;

    modport source (output valid, output rh_tenths, output rh_percent, input ready);
    modport sink   (input valid, input rh_tenths, input rh_percent, output ready);
endinterface

### rtl/humidity_temperature_compensation.sv
`timescale 1ns / 1ps

// humidity compensation for sensor self-heating. each input beat carries a temperature in
// 0.01 C and a raw humidity in 0.01 %RH; each one yields exactly one output beat with the
// corrected humidity in 0.1 %RH (clamped to 0..rh_ceiling) and in whole percent. the block
// is a 17-stage pipeline followed by an output register with a one-entry skid buffer: it
// takes one beat per clock while the skid entry is empty, and a beat waits in the skid entry
// when the sink stalls. the depth is set by the signed q0.40 cubic (three horner multiplies),
// the five-stage digit divider that reduces the cubic by 1000, and the split 19x41 correction
// multiply. i_in.ready drops only when the skid entry is full. the five registers sit on an
// apb port at byte addresses 0, 4, 8, 12, 16 (knee_temp, cold_delta, delta_min, delta_max,
// rh_ceiling) and may be written only while no beat is in flight.
module humidity_temperature_compensation import htc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    htc_in_if.sink                i_in,
    htc_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int unsigned NS      = 17;  // pipeline stages before the output register
    localparam int unsigned NDIG    = 5;   // decimal-thousand digit stages
    localparam int unsigned LAST    = NS - 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [11:0] r_knee;
    logic signed [7:0]  r_cold;
    logic signed [7:0]  r_dmin;
    logic signed [7:0]  r_dmax;
    logic        [9:0]  r_ceil;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knee <= KNEE_TEMP_RST;
            r_cold <= COLD_DELTA_RST;
            r_dmin <= DELTA_MIN_RST;
            r_dmax <= DELTA_MAX_RST;
            r_ceil <= RH_CEILING_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_KNEE_TEMP:  r_knee <= pwdata[11:0];
                REG_COLD_DELTA: r_cold <= pwdata[7:0];
                REG_DELTA_MIN:  r_dmin <= pwdata[7:0];
                REG_DELTA_MAX:  r_dmax <= pwdata[7:0];
                REG_RH_CEILING: r_ceil <= pwdata[9:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // read back, signed registers sign-extended
    always_comb begin
        unique case (paddr[4:2])
            REG_KNEE_TEMP:  prdata = 32'(r_knee);
            REG_COLD_DELTA: prdata = 32'(r_cold);
            REG_DELTA_MIN:  prdata = 32'(r_dmin);
            REG_DELTA_MAX:  prdata = 32'(r_dmax);
            REG_RH_CEILING: prdata = 32'(r_ceil);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // flow control: whole pipeline advances unless the skid entry is full
    // ------------------------------------------------------------------
    logic [NS-1:0] r_vld;
    logic          r_skid_vld;
    logic          r_out_vld;
    logic          w_adv;
    logic          w_out_free;
    logic          w_skid_load;

    assign w_adv       = !r_skid_vld;
    assign w_out_free  = !r_out_vld || o_out.ready;
    assign w_skid_load = !r_skid_vld && !w_out_free && r_vld[LAST];
    assign i_in.ready  = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-2:0], i_in.valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 0: t10 and h10, both truncated toward zero
    // ------------------------------------------------------------------
    logic               w_t_neg;
    logic        [14:0] w_t_mag;
    logic        [14:0] w_t_q;
    logic signed [11:0] w_t_qs;
    logic        [14:0] w_h_q;
    logic signed [11:0] r_s0_t10;
    logic        [10:0] r_s0_h10;

    assign w_t_neg = i_in.temp_centi[14];
    assign w_t_mag = w_t_neg ? (15'd0 - i_in.temp_centi) : i_in.temp_centi;
    assign w_t_q   = f_div10({3'b000, w_t_mag});
    assign w_t_qs  = {1'b0, w_t_q[10:0]};
    assign w_h_q   = f_div10({4'b0000, i_in.rh_centi});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_t10 <= w_t_neg ? -w_t_qs : w_t_qs;
            r_s0_h10 <= w_h_q[10:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 1: first horner step, linear delta above the knee
    // ------------------------------------------------------------------
    logic signed [30:0] w_ax;
    logic signed [30:0] w_p1;
    logic signed [15:0] w_lx;
    logic               w_l_neg;
    logic        [15:0] w_l_mag;
    logic        [14:0] w_l_q;
    logic signed [9:0]  w_l_qs;
    logic signed [28:0] r_s1_p1;
    logic signed [9:0]  r_s1_dlin;
    logic signed [11:0] r_s1_t10;
    logic        [10:0] r_s1_h10;

    assign w_ax    = CUBIC_A * 31'(r_s0_t10);
    assign w_p1    = CUBIC_B10 - w_ax;
    assign w_lx    = 16'(r_s0_t10) * LIN_SLOPE - LIN_OFFSET;
    assign w_l_neg = w_lx[15];
    assign w_l_mag = w_l_neg ? (16'd0 - w_lx) : w_lx;
    assign w_l_q   = f_div100({6'd0, w_l_mag[14:0]});
    assign w_l_qs  = {1'b0, w_l_q[8:0]};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_p1   <= w_p1[28:0];
            r_s1_dlin <= w_l_neg ? -w_l_qs : w_l_qs;
            r_s1_t10  <= r_s0_t10;
            r_s1_h10  <= r_s0_h10;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: second horner step, delta select and clamps
    // ------------------------------------------------------------------
    logic signed [41:0] w_tp1;
    logic signed [41:0] w_p2;
    logic signed [9:0]  w_d0;
    logic signed [9:0]  w_d1;
    logic signed [9:0]  w_d2;
    logic signed [39:0] r_s2_p2;
    logic signed [7:0]  r_s2_delta;
    logic signed [11:0] r_s2_t10;
    logic        [10:0] r_s2_h10;

    assign w_tp1 = 42'(r_s1_t10) * 42'(r_s1_p1);
    assign w_p2  = w_tp1 - CUBIC_C100;
    assign w_d0  = (r_s1_t10 >= r_knee) ? r_s1_dlin : 10'(r_cold);
    // lower clamp first, upper clamp wins when the two cross
    assign w_d1  = (w_d0 < 10'(r_dmin)) ? 10'(r_dmin) : w_d0;
    assign w_d2  = (w_d1 > 10'(r_dmax)) ? 10'(r_dmax) : w_d1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_p2    <= w_p2[39:0];
            r_s2_delta <= w_d2[7:0];
            r_s2_t10   <= r_s1_t10;
            r_s2_h10   <= r_s1_h10;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: last horner step, cubic numerator over 1000
    // ------------------------------------------------------------------
    logic signed [52:0] w_tp2;
    logic signed [52:0] w_n;
    logic signed [50:0] r_s3_n;
    logic signed [7:0]  r_s3_delta;
    logic        [10:0] r_s3_h10;

    assign w_tp2 = 53'(r_s2_t10) * 53'(r_s2_p2);
    assign w_n   = w_tp2 + CUBIC_D1000;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_n     <= w_n[50:0];
            r_s3_delta <= r_s2_delta;
            r_s3_h10   <= r_s2_h10;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: sign/magnitude of the numerator, g = delta * -h10
    // ------------------------------------------------------------------
    logic signed [50:0] w_n_mag;
    logic signed [18:0] w_dh;
    logic               r_s4_neg;
    logic        [49:0] r_s4_mag;
    logic signed [18:0] r_s4_g;
    logic        [10:0] r_s4_h10;

    assign w_n_mag = r_s3_n[50] ? -r_s3_n : r_s3_n;
    assign w_dh    = 19'(r_s3_delta) * 19'($signed({1'b0, r_s3_h10}));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_neg <= r_s3_n[50];
            r_s4_mag <= w_n_mag[49:0];
            r_s4_g   <= -w_dh;
            r_s4_h10 <= r_s3_h10;
        end
    end

    // ------------------------------------------------------------------
    // stages 5-9: long division of the magnitude by 1000, ten bits a stage
    // ------------------------------------------------------------------
    logic        [9:0]  r_dv_r   [NDIG];
    logic        [39:0] r_dv_q   [NDIG];
    logic        [49:0] r_dv_m   [NDIG];
    logic               r_dv_neg [NDIG];
    logic signed [18:0] r_dv_g   [NDIG];
    logic        [10:0] r_dv_h   [NDIG];

    logic        [9:0]  w_rp [NDIG];
    logic        [39:0] w_qp [NDIG];
    logic        [49:0] w_mp [NDIG];
    logic               w_np [NDIG];
    logic signed [18:0] w_gp [NDIG];
    logic        [10:0] w_hp [NDIG];

    always_comb begin
        w_rp[0] = '0;
        w_qp[0] = '0;
        w_mp[0] = r_s4_mag;
        w_np[0] = r_s4_neg;
        w_gp[0] = r_s4_g;
        w_hp[0] = r_s4_h10;
        for (int j = 1; j < NDIG; j++) begin
            w_rp[j] = r_dv_r[j-1];
            w_qp[j] = r_dv_q[j-1];
            w_mp[j] = r_dv_m[j-1];
            w_np[j] = r_dv_neg[j-1];
            w_gp[j] = r_dv_g[j-1];
            w_hp[j] = r_dv_h[j-1];
        end
    end

    for (genvar j = 0; j < NDIG; j++) begin : g_digit
        logic [19:0] w_x;
        logic [9:0]  w_q;
        logic [19:0] w_r;

        // remainder below 1000 joined with the next ten bits
        assign w_x = {w_rp[j], w_mp[j][49-10*j -: 10]};
        assign w_q = f_div1000_digit(w_x);
        assign w_r = w_x - 20'(w_q) * DIGIT_BASE;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_r[j]   <= w_r[9:0];
                r_dv_q[j]   <= {w_qp[j][29:0], w_q};
                r_dv_m[j]   <= w_mp[j];
                r_dv_neg[j] <= w_np[j];
                r_dv_g[j]   <= w_gp[j];
                r_dv_h[j]   <= w_hp[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 10: signed vapour factor f in q0.40
    // ------------------------------------------------------------------
    logic signed [40:0] w_fq;
    logic signed [40:0] r_s10_f;
    logic signed [18:0] r_s10_g;
    logic        [10:0] r_s10_h10;

    assign w_fq = {1'b0, r_dv_q[NDIG-1]};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s10_f   <= r_dv_neg[NDIG-1] ? -w_fq : w_fq;
            r_s10_g   <= r_dv_g[NDIG-1];
            r_s10_h10 <= r_dv_h[NDIG-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 11: g * f as two partial products (f split at bit 20)
    // ------------------------------------------------------------------
    logic signed [39:0] w_plo;
    logic signed [39:0] w_phi;
    logic signed [39:0] r_s11_plo;
    logic signed [39:0] r_s11_phi;
    logic        [10:0] r_s11_h10;

    assign w_plo = 40'(r_s10_g) * 40'($signed({1'b0, r_s10_f[19:0]}));
    assign w_phi = 40'(r_s10_g) * 40'($signed(r_s10_f[40:20]));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s11_plo <= w_plo;
            r_s11_phi <= w_phi;
            r_s11_h10 <= r_s10_h10;
        end
    end

    // ------------------------------------------------------------------
    // stage 12: recombine the partial products
    // ------------------------------------------------------------------
    logic signed [59:0] w_prod;
    logic signed [58:0] r_s12_prod;
    logic        [10:0] r_s12_h10;

    assign w_prod = $signed({r_s11_phi, 20'd0}) + 60'(r_s11_plo);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s12_prod <= w_prod[58:0];
            r_s12_h10  <= r_s11_h10;
        end
    end

    // ------------------------------------------------------------------
    // stage 13: magnitude over 2^40
    // ------------------------------------------------------------------
    logic signed [58:0] w_pmag;
    logic               r_s13_neg;
    logic        [17:0] r_s13_cmag;
    logic        [10:0] r_s13_h10;

    assign w_pmag = r_s12_prod[58] ? -r_s12_prod : r_s12_prod;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s13_neg  <= r_s12_prod[58];
            r_s13_cmag <= w_pmag[57:40];
            r_s13_h10  <= r_s12_h10;
        end
    end

    // ------------------------------------------------------------------
    // stage 14: correction = trunc(delta * -h10 * f / (10 * 2^40))
    // ------------------------------------------------------------------
    logic        [14:0] w_c;
    logic signed [15:0] w_cs;
    logic signed [15:0] r_s14_corr;
    logic        [10:0] r_s14_h10;

    assign w_c  = f_div10(r_s13_cmag);
    assign w_cs = {1'b0, w_c};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s14_corr <= r_s13_neg ? -w_cs : w_cs;
            r_s14_h10  <= r_s13_h10;
        end
    end

    // ------------------------------------------------------------------
    // stage 15: (h10 + corr) * 92
    // ------------------------------------------------------------------
    logic signed [16:0] w_sum;
    logic signed [21:0] r_s15_sp;

    assign w_sum = 17'($signed({1'b0, r_s14_h10})) + 17'(r_s14_corr);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s15_sp <= 22'(w_sum) * RH_SCALE;
        end
    end

    // ------------------------------------------------------------------
    // stage 16: divide by 100, clamp to 0..rh_ceiling
    // ------------------------------------------------------------------
    logic [14:0] w_sq;
    logic [9:0]  r_s16_tenths;

    assign w_sq = f_div100(r_s15_sp[20:0]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_s15_sp <= 22'sd0) begin
                r_s16_tenths <= '0;  // sums of zero or below clamp to zero
            end else if (w_sq > 15'(r_ceil)) begin
                r_s16_tenths <= r_ceil;
            end else begin
                r_s16_tenths <= w_sq[9:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register with one skid entry
    // ------------------------------------------------------------------
    logic [14:0]  w_pct;
    t_rh_tenths   r_out_tenths;
    t_rh_percent  r_out_percent;
    t_rh_tenths   r_skid_tenths;
    t_rh_percent  r_skid_percent;

    assign w_pct = f_div10({8'd0, r_s16_tenths});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_vld <= r_skid_vld || r_vld[LAST];
            end
            r_skid_vld <= r_skid_vld ? !w_out_free : w_skid_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_vld) begin
                r_out_tenths  <= r_skid_tenths;
                r_out_percent <= r_skid_percent;
            end else begin
                r_out_tenths  <= r_s16_tenths;
                r_out_percent <= w_pct[6:0];
            end
        end
        if (w_skid_load) begin
            r_skid_tenths  <= r_s16_tenths;
            r_skid_percent <= w_pct[6:0];
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.rh_tenths  = r_out_tenths;
    assign o_out.rh_percent = r_out_percent;

endmodule

### rtl/htc_checker.sv
`timescale 1ns / 1ps

module htc_checker import htc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input t_rh_tenths            i_rh_tenths,
    input t_rh_percent           i_rh_percent,
    input logic                  i_psel,
    input logic                  i_penable,
    input logic                  i_pwrite,
    input logic [CFG_ADDR_W-1:0] i_paddr,
    input logic [31:0]           i_pwdata
);

    // shadow of the ceiling register
    logic [9:0] r_ceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceil <= RH_CEILING_RST;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[4:2] == REG_RH_CEILING)) begin
            r_ceil <= i_pwdata[9:0];
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_rh_tenths) && $stable(i_rh_percent))
        else $error("output beat changed while stalled");

    a_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_rh_tenths <= r_ceil)
        else $error("humidity above ceiling");

    a_percent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (11'(i_rh_percent) * 11'd10 <= 11'(i_rh_tenths))
                     && (11'(i_rh_tenths) < 11'(i_rh_percent) * 11'd10 + 11'd10))
        else $error("percent does not match tenths");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready && i_out_ready |=> i_in_ready && i_in_valid == i_in_valid)
        else $error("input held off after output drained");

endmodule

bind humidity_temperature_compensation htc_checker u_htc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_rh_tenths  (o_out.rh_tenths),
    .i_rh_percent (o_out.rh_percent),
    .i_psel       (psel),
    .i_penable    (penable),
    .i_pwrite     (pwrite),
    .i_paddr      (paddr),
    .i_pwdata     (pwdata)
);
